### rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and pixel transforms for the RGB565 crop and
// decimation unit.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // Default geometry
  localparam int unsigned SrcWidthDef    = 320;
  localparam int unsigned SrcHeightDef   = 240;
  localparam int unsigned OutWidthDef    = 160;
  localparam int unsigned OutHeightDef   = 80;
  localparam int unsigned CompareStepDef = 4;

  // Field widths
  localparam int unsigned PixW   = 16;
  localparam int unsigned OutXW  = 8;
  localparam int unsigned OutYW  = 7;
  localparam int unsigned RowCfgW = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 8;

  localparam logic [RowCfgW-1:0] FirstRowRst = 8'd40;

  // RGB565 field masks
  localparam logic [PixW-1:0] BlueMask  = 16'h001F;
  localparam logic [PixW-1:0] GreenMask = 16'h07E0;
  localparam logic [PixW-1:0] RedMask   = 16'hF800;
  localparam int unsigned     RbShift   = 11;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPARE_MODE  = 8'd0,
    CFG_SWAP_BYTES    = 8'd1,
    CFG_SWAP_RED_BLUE = 8'd2,
    CFG_FIRST_ROW     = 8'd3
  } cfg_reg_e;

  // Channel payloads
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [OutXW-1:0] out_x;
    logic [OutYW-1:0] out_y;
    logic [PixW-1:0]  out_pixel;
    logic             last;
  } res_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_wr_t;

  // Byte exchange, then red/blue exchange
  function automatic logic [PixW-1:0] rgb_xform(input logic [PixW-1:0] px,
                                                input logic swap_b,
                                                input logic swap_rb);
    logic [PixW-1:0] t;
    t = swap_b ? {px[7:0], px[15:8]} : px;
    if (swap_rb) begin
      t = ((t & BlueMask) << RbShift) | (t & GreenMask) | ((t & RedMask) >> RbShift);
    end
    return t;
  endfunction

endpackage

### rtl/rcd_chan_if.sv
// ----------------------------------------------------------------------------
// rcd_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface rcd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rgb565_crop_decimate_unit.sv
// ----------------------------------------------------------------------------
// rgb565_crop_decimate_unit
// Crops and decimates a raster RGB565 stream into a preview image, or fans
// each grid pixel out into four transform quadrants in compare mode.
// ----------------------------------------------------------------------------
// Each accepted pixel passes through an input register and a result register.
// In normal mode the unit takes one pixel per cycle with or without a result,
// as long as the receiver takes each result. In compare mode a kept pixel
// occupies the result register for four output transfers, so the input
// stalls while the next kept pixel waits for it; pixels with no result still
// pass one per cycle while the result register is busy, until the next kept
// pixel reaches it. Config writes are taken in any cycle and must only be
// issued while the unit is idle.
module rgb565_crop_decimate_unit
  import rcd_pkg::*;
#(
  parameter int unsigned SRC_WIDTH    = SrcWidthDef,
  parameter int unsigned SRC_HEIGHT   = SrcHeightDef,
  parameter int unsigned OUT_WIDTH    = OutWidthDef,
  parameter int unsigned OUT_HEIGHT   = OutHeightDef,
  parameter int unsigned COMPARE_STEP = CompareStepDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcd_chan_if.sink    pix_in,
  rcd_chan_if.source  res_out,
  rcd_chan_if.sink    cfg_in
);
  localparam int unsigned ColW = $clog2(SRC_WIDTH);
  localparam int unsigned RowW = $clog2(SRC_HEIGHT);
  localparam int unsigned DW   = (RowW > RowCfgW) ? RowW : RowCfgW;
  localparam int unsigned Qw   = OUT_WIDTH / 2;
  localparam int unsigned Qh   = OUT_HEIGHT / 2;
  localparam logic [OutXW-1:0] QwX = OutXW'(Qw);
  localparam logic [OutYW-1:0] QhY = OutYW'(Qh);
  localparam logic [ColW-1:0] ColLast = ColW'(SRC_WIDTH - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(SRC_HEIGHT - 1);

  // Configuration registers
  logic               compare_q;
  logic               swap_b_q;
  logic               swap_rb_q;
  logic [RowCfgW-1:0] first_row_q;

  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_q   <= 1'b0;
      swap_b_q    <= 1'b0;
      swap_rb_q   <= 1'b0;
      first_row_q <= FirstRowRst;
    end else if (cfg_in.valid) begin
      unique case (cfg_in.data.index)
        CFG_COMPARE_MODE:  compare_q   <= cfg_in.data.data[0];
        CFG_SWAP_BYTES:    swap_b_q    <= cfg_in.data.data[0];
        CFG_SWAP_RED_BLUE: swap_rb_q   <= cfg_in.data.data[0];
        CFG_FIRST_ROW:     first_row_q <= cfg_in.data.data;
        default: ;
      endcase
    end
  end

  // Position counters and input register
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] pos_col;
  logic [RowW-1:0] pos_row;
  logic            a_valid_q;
  logic [PixW-1:0] a_pix_q;
  logic [ColW-1:0] a_col_q;
  logic [RowW-1:0] a_row_q;
  logic            in_xfer;
  logic            a_keep;
  logic            a_take;
  logic            b_free;

  assign pos_col = pix_in.data.frame_start ? '0 : col_q;
  assign pos_row = pix_in.data.frame_start ? '0 : row_q;
  assign in_xfer = pix_in.valid && pix_in.ready;

  // A held item leaves when it drops out or the result register is free
  assign a_take       = a_valid_q && (!a_keep || b_free);
  assign pix_in.ready = !a_valid_q || a_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (pos_col == ColLast) begin
          col_q <= '0;
          row_q <= (pos_row == RowLast) ? '0 : pos_row + RowW'(1);
        end else begin
          col_q <= pos_col + ColW'(1);
          row_q <= pos_row;
        end
        a_valid_q <= 1'b1;
      end else if (a_take) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_pix_q <= pix_in.data.pixel;
      a_col_q <= pos_col;
      a_row_q <= pos_row;
    end
  end

  // Window decision
  logic [DW-1:0]   row_ext;
  logic [DW-1:0]   fr_ext;
  logic [DW-1:0]   row_dist;
  logic            in_rows;
  logic [ColW-1:0] cq;
  logic [ColW-1:0] cr;
  logic [DW-1:0]   dq;
  logic [DW-1:0]   dr;
  logic            keep_norm;
  logic            keep_cmp;
  logic [OutXW-1:0] x_base;
  logic [OutYW-1:0] y_base;
  logic [PixW-1:0]  pix_base;

  assign row_ext  = DW'(a_row_q);
  assign fr_ext   = DW'(first_row_q);
  assign in_rows  = row_ext >= fr_ext;
  assign row_dist = row_ext - fr_ext;

  rcd_cdiv #(.WIDTH(ColW), .DIVISOR(COMPARE_STEP)) u_col_div (
    .value_i (a_col_q),
    .quot_o  (cq),
    .rem_o   (cr)
  );

  rcd_cdiv #(.WIDTH(DW), .DIVISOR(COMPARE_STEP)) u_row_div (
    .value_i (row_dist),
    .quot_o  (dq),
    .rem_o   (dr)
  );

  assign keep_norm = in_rows && !a_col_q[0] && !row_dist[0]
                     && (32'(a_col_q >> 1) < OUT_WIDTH)
                     && (32'(row_dist >> 1) < OUT_HEIGHT);
  assign keep_cmp  = in_rows && (cr == '0) && (dr == '0)
                     && (32'(cq) < Qw) && (32'(dq) < Qh);
  assign a_keep    = compare_q ? keep_cmp : keep_norm;

  always_comb begin
    if (compare_q) begin
      x_base   = OutXW'(cq);
      y_base   = OutYW'(dq);
      pix_base = a_pix_q;
    end else begin
      x_base   = OutXW'(a_col_q >> 1);
      y_base   = OutYW'(row_dist >> 1);
      pix_base = rgb_xform(a_pix_q, swap_b_q, swap_rb_q);
    end
  end

  // Result register with quadrant counter
  logic             b_valid_q;
  logic             b_cmp_q;
  logic [1:0]       b_quad_q;
  logic [OutXW-1:0] b_x_q;
  logic [OutYW-1:0] b_y_q;
  logic [PixW-1:0]  b_pix_q;
  logic             b_last;
  logic             out_xfer;
  logic             b_load;

  assign b_last   = !b_cmp_q || (b_quad_q == 2'd3);
  assign out_xfer = res_out.valid && res_out.ready;
  assign b_free   = !b_valid_q || (out_xfer && b_last);
  assign b_load   = a_valid_q && a_keep && b_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_quad_q  <= '0;
    end else begin
      if (b_load) begin
        b_valid_q <= 1'b1;
        b_quad_q  <= '0;
      end else if (out_xfer) begin
        b_valid_q <= !b_last;
        b_quad_q  <= b_quad_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_cmp_q <= compare_q;
      b_x_q   <= x_base;
      b_y_q   <= y_base;
      b_pix_q <= pix_base;
    end
  end

  // Quadrant placement: right half swaps red/blue, lower half swaps bytes
  assign res_out.valid          = b_valid_q;
  assign res_out.data.out_x     = (b_cmp_q && b_quad_q[0]) ? b_x_q + QwX : b_x_q;
  assign res_out.data.out_y     = (b_cmp_q && b_quad_q[1]) ? b_y_q + QhY : b_y_q;
  assign res_out.data.out_pixel = b_cmp_q ? rgb_xform(b_pix_q, b_quad_q[1], b_quad_q[0])
                                          : b_pix_q;
  assign res_out.data.last      = b_last;

endmodule

### rtl/rcd_cdiv.sv
// ----------------------------------------------------------------------------
// rcd_cdiv
// Division of an unsigned value by a small constant: reciprocal multiply
// giving a quotient at most one low, then a single correction step.
// ----------------------------------------------------------------------------
module rcd_cdiv #(
  parameter int unsigned WIDTH   = 12,
  parameter int unsigned DIVISOR = 4
) (
  input  logic [WIDTH-1:0] value_i,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);
  // floor(2^WIDTH / DIVISOR), so the estimate never overshoots
  localparam int unsigned MulInt = (2 ** WIDTH) / DIVISOR;
  localparam logic [WIDTH:0] Mul = (WIDTH + 1)'(MulInt);
  localparam logic [WIDTH-1:0] Div = WIDTH'(DIVISOR);

  logic [2*WIDTH:0]  prod;
  logic [WIDTH-1:0]  q0;
  logic [WIDTH-1:0]  r0;

  assign prod = (2*WIDTH+1)'(value_i) * (2*WIDTH+1)'(Mul);
  assign q0   = prod[2*WIDTH-1:WIDTH];
  assign r0   = value_i - WIDTH'(q0 * Div);

  // one correction step
  always_comb begin
    if (r0 >= Div) begin
      quot_o = q0 + WIDTH'(1);
      rem_o  = r0 - Div;
    end else begin
      quot_o = q0;
      rem_o  = r0;
    end
  end
endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rgb565_crop_decimate_unit. A clocked driver feeds raster
// pixels from a pending queue, a clocked monitor tracks the source position
// and crop settings, predicts the preview pixels each transfer must produce,
// and compares every result transfer against the oldest prediction.
// Directed pixels are followed by short random phases with varied idling and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf        = 4;
  localparam int unsigned QuadW          = OutWidthDef / 2;
  localparam int unsigned QuadH          = OutHeightDef / 2;
  localparam int unsigned RandPerPhase   = 62;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxReports     = 40;
  localparam int unsigned RunLimitNs     = 10_000_000;
  // index with no register behind it, writes must be dropped
  localparam logic [CfgIdxW-1:0] UnusedRegIdx = 8'd9;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driven channel signals, known from time zero
  logic     pix_vld = 1'b0;
  pix_in_t  pix_dat = '0;
  logic     res_rdy = 1'b0;
  logic     cfg_vld = 1'b0;
  cfg_wr_t  cfg_dat = '0;

  rcd_chan_if #(.T(pix_in_t))  pix_if ();
  rcd_chan_if #(.T(res_out_t)) res_if ();
  rcd_chan_if #(.T(cfg_wr_t))  cfg_if ();

  assign pix_if.valid = pix_vld;
  assign pix_if.data  = pix_dat;
  assign res_if.ready = res_rdy;
  assign cfg_if.valid = cfg_vld;
  assign cfg_if.data  = cfg_dat;

  rgb565_crop_decimate_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_if),
    .res_out (res_if),
    .cfg_in  (cfg_if)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Stimulus and scoreboard state
  pix_in_t     pending_pix_q[$];
  res_out_t    expected_px_q[$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  logic        pix_fire     = 1'b0;

  // Idling knobs
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        long_hold_on  = 1'b0;
  int unsigned hold_cnt      = 0;

  // Predictor copy of position and settings
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  logic        cmp_mode = 1'b0;
  logic        swap_b   = 1'b0;
  logic        swap_rb  = 1'b0;
  logic [7:0]  crop_row = FirstRowRst;

  // Byte exchange first, then red and blue fields
  function automatic logic [15:0] xform_rgb(logic [15:0] px, logic sb, logic srb);
    logic [15:0] t;
    t = sb ? {px[7:0], px[15:8]} : px;
    if (srb) begin
      t = {t[4:0], t[10:5], t[15:11]};
    end
    return t;
  endfunction

  function automatic res_out_t mk_res(int unsigned x, int unsigned y, logic [15:0] px,
                                      logic lst);
    return res_out_t'{out_x: 8'(x), out_y: 7'(y), out_pixel: px, last: lst};
  endfunction

  // Position tracking and preview pixel prediction for one input transfer
  function automatic void predict_preview(pix_in_t p);
    int unsigned d;
    int unsigned lx;
    int unsigned ly;
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (row_pos >= crop_row) begin
      d = row_pos - crop_row;
      if (!cmp_mode) begin
        if (col_pos % 2 == 0 && d % 2 == 0 && col_pos / 2 < OutWidthDef &&
            d / 2 < OutHeightDef) begin
          expected_px_q.push_back(mk_res(col_pos / 2, d / 2,
                                         xform_rgb(p.pixel, swap_b, swap_rb), 1'b1));
        end
      end else if (col_pos % CompareStepDef == 0 && d % CompareStepDef == 0 &&
                   col_pos / CompareStepDef < QuadW && d / CompareStepDef < QuadH) begin
        lx = col_pos / CompareStepDef;
        ly = d / CompareStepDef;
        expected_px_q.push_back(mk_res(lx, ly, p.pixel, 1'b0));
        expected_px_q.push_back(mk_res(lx + QuadW, ly, xform_rgb(p.pixel, 1'b0, 1'b1), 1'b0));
        expected_px_q.push_back(mk_res(lx, ly + QuadH, xform_rgb(p.pixel, 1'b1, 1'b0), 1'b0));
        expected_px_q.push_back(mk_res(lx + QuadW, ly + QuadH,
                                       xform_rgb(p.pixel, 1'b1, 1'b1), 1'b1));
      end
    end
    col_pos++;
    if (col_pos >= SrcWidthDef) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= SrcHeightDef) begin
        row_pos = 0;
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (err_cnt < MaxReports) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
      err_cnt++;
    end
  endfunction

  // Monitor: input transfers, register writes and result checks
  always @(posedge clk_i) begin : monitor
    res_out_t want;
    res_out_t got;
    pix_fire <= pix_vld && pix_if.ready;
    if (pix_vld && pix_if.ready) begin
      predict_preview(pix_if.data);
      accepted_cnt++;
    end
    if (cfg_vld && cfg_if.ready) begin
      case (cfg_if.data.index)
        CFG_COMPARE_MODE:  cmp_mode = cfg_if.data.data[0];
        CFG_SWAP_BYTES:    swap_b   = cfg_if.data.data[0];
        CFG_SWAP_RED_BLUE: swap_rb  = cfg_if.data.data[0];
        CFG_FIRST_ROW:     crop_row = cfg_if.data.data;
        default: ;
      endcase
    end
    if (res_if.valid && res_rdy) begin
      got = res_if.data;
      if (expected_px_q.size() == 0) begin
        if (err_cnt < MaxReports) begin
          $error("result with nothing expected: x=%0d y=%0d pixel=0x%0h",
                 got.out_x, got.out_y, got.out_pixel);
        end
        err_cnt++;
      end else begin
        want = expected_px_q.pop_front();
        check_field("out_x", want.out_x, got.out_x);
        check_field("out_y", want.out_y, got.out_y);
        check_field("out_pixel", want.out_pixel, got.out_pixel);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Pixel driver: hold the offer until taken, idle at random between offers
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_vld <= 1'b0;
    end else if (!pix_vld || pix_fire) begin
      if (pending_pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_dat <= pending_pix_q.pop_front();
        pix_vld <= 1'b1;
      end else begin
        pix_vld <= 1'b0;
      end
    end
  end

  // Result receiver: one long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_rdy <= 1'b0;
    end else if (long_hold_on && hold_cnt < LongHoldCycles) begin
      res_rdy  <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      res_rdy <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void push_pix(logic [15:0] px, logic fs);
    pending_pix_q.push_back(pix_in_t'{pixel: px, frame_start: fs});
    queued_cnt++;
  endfunction

  // Raster run with random content, frame start on the first pixel and at random resyncs
  function automatic void queue_raster(int unsigned n, int unsigned resync_pct);
    for (int unsigned i = 0; i < n; i++) begin
      push_pix(16'($urandom), (i == 0) || ($urandom_range(99) < resync_pct));
    end
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_dat <= cfg_wr_t'{index: idx, data: val};
    cfg_vld <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_vld <= 1'b0;
  endtask

  task automatic apply_cfg(logic cmp, logic sb, logic srb, logic [7:0] fr);
    write_reg(CFG_COMPARE_MODE, {7'd0, cmp});
    write_reg(CFG_SWAP_BYTES, {7'd0, sb});
    write_reg(CFG_SWAP_RED_BLUE, {7'd0, srb});
    write_reg(CFG_FIRST_ROW, fr);
  endtask

  // Every queued pixel taken, every prediction met, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk_i); while (accepted_cnt != queued_cnt || expected_px_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned send_pct[4];
    int unsigned rcv_pct[4];
    send_pct = '{0, 87, 0, 29};
    rcv_pct  = '{0, 0, 87, 29};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: window opens at row 40, so row 0 gives nothing
    push_pix(16'h0000, 1'b1);
    push_pix(16'hFFFF, 1'b0);
    wait_drained();

    // Plain decimation from row 0; upper data bits of a flag are dropped
    write_reg(CFG_FIRST_ROW, 8'd0);
    write_reg(CFG_SWAP_BYTES, 8'hFE);
    push_pix(16'h0000, 1'b1);
    push_pix(16'hFFFF, 1'b0);
    push_pix(16'hF800, 1'b0);
    push_pix(16'h1234, 1'b0);
    push_pix(16'h001F, 1'b0);
    wait_drained();

    // Byte swap only
    write_reg(CFG_SWAP_BYTES, 8'd1);
    push_pix(16'hF81F, 1'b1);
    push_pix(16'h00FF, 1'b0);
    push_pix(16'h12AB, 1'b0);
    wait_drained();

    // Red/blue swap only
    write_reg(CFG_SWAP_BYTES, 8'd0);
    write_reg(CFG_SWAP_RED_BLUE, 8'd1);
    push_pix(16'hF800, 1'b1);
    push_pix(16'h0000, 1'b0);
    push_pix(16'h07FF, 1'b0);
    wait_drained();

    // Both swaps, byte exchange first
    write_reg(CFG_SWAP_BYTES, 8'd1);
    push_pix(16'hF8E0, 1'b1);
    push_pix(16'h5555, 1'b0);
    push_pix(16'h001F, 1'b0);
    wait_drained();

    // Compare mode, grid pixels at columns 0 and 4; a stray write is ignored
    write_reg(UnusedRegIdx, 8'hFF);
    write_reg(CFG_COMPARE_MODE, 8'd1);
    push_pix(16'hF81F, 1'b1);
    push_pix(16'hAAAA, 1'b0);
    push_pix(16'h5555, 1'b0);
    push_pix(16'hFFFF, 1'b0);
    push_pix(16'h07E0, 1'b0);
    wait_drained();

    // Crop window below the frame: nothing may come out
    write_reg(CFG_FIRST_ROW, 8'hFF);
    push_pix(16'hFFFF, 1'b1);
    push_pix(16'h0000, 1'b0);
    wait_drained();

    // Random phases; the first one opens the window at row 0 in compare mode
    // and also holds the receiver off for a while
    for (int ph = 0; ph < 4; ph++) begin
      apply_cfg((ph == 0) ? 1'b1 : 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), (ph == 0) ? 8'd0 : 8'($urandom_range(2)));
      send_idle_pct = send_pct[ph];
      stall_pct     = rcv_pct[ph];
      if (ph == 0) begin
        long_hold_on = 1'b1;
      end
      queue_raster(RandPerPhase, 2);
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(RunLimitNs);
    $display("simulation failed");
    $finish;
  end

endmodule
